[sv/gmed_pkg.sv]
// gmed_pkg: shared types and constants of the grid median energy density block
// no dependencies; imported by gmed_locate, gmed_rho and the top level

package gmed_pkg;

    // default grid shape and cell sum width
    localparam int ETA_CELLS_DEF = 8;
    localparam int PHI_CELLS_DEF = 10;
    localparam int SUM_BITS_DEF  = 24;

    // payload widths
    localparam int ETA_W = 14;
    localparam int PHI_W = 15;
    localparam int PT_W  = 20;
    localparam int RHO_W = 26;

    // widest grid index (up to 16 cells per axis)
    localparam int IDX_W = 4;

    // eta grid in milli-units, phi codes per full turn
    localparam int ETA_FIRST = -2100;
    localparam int ETA_STEP  = 600;
    localparam int ETA_HALF  = 300;
    localparam int PHI_CODES = 20480;

    // rho scaling: floor(s * 43461 * phi_cells / 327680), clipped to 26 bits
    localparam int          RHO_MULT = 43461;
    localparam int          RHO_DEN  = 327680;
    localparam int          SCALED_W = 28;
    localparam logic [25:0] RHO_MAX  = 26'h3FFFFFF;

    // cells a candidate touches: up to two eta rows and two phi columns
    typedef struct packed {
        logic             eta_any;
        logic             eta_two;
        logic [IDX_W-1:0] eta_lo;
        logic [IDX_W-1:0] eta_hi;
        logic             phi_two;
        logic [IDX_W-1:0] phi_lo;
        logic [IDX_W-1:0] phi_hi;
    } cell_span_t;

    // control sequencer
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_START,
        ST_SCALE,
        ST_OUT
    } state_t;

endpackage

[sv/gmed_ram.sv]
// gmed_ram: generic single write port, single read port memory
// registered read data; no dependencies

module gmed_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 80
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/gmed_locate.sv]
// gmed_locate: finds the eta rows and phi columns a candidate falls into
// depends on gmed_pkg; result registered when a word is taken

module gmed_locate #(
    parameter int ETA_CELLS = gmed_pkg::ETA_CELLS_DEF,
    parameter int PHI_CELLS = gmed_pkg::PHI_CELLS_DEF
) (
    input  logic                            clk,
    input  logic                            load,
    input  logic signed [gmed_pkg::ETA_W-1:0] eta,
    input  logic [gmed_pkg::PHI_W-1:0]      phi,
    output gmed_pkg::cell_span_t            span
);

    import gmed_pkg::*;

    // scaled phi: phi * PHI_CELLS, one column spans PHI_CODES of it
    localparam int YW = $clog2(PHI_CELLS * PHI_CODES + 1);

    logic [PHI_W-1:0]     phi_m;
    logic [YW-1:0]        phi_y;
    logic signed [15:0]   eta_x;
    logic [ETA_CELLS-1:0] eta_hit;
    logic [PHI_CELLS-1:0] phi_hit;
    cell_span_t           span_next;
    cell_span_t           span_reg;

    // membership tests, one per row and per column, edges inclusive
    always_comb
    begin
        phi_m = (phi >= PHI_W'(PHI_CODES)) ? phi - PHI_W'(PHI_CODES) : phi;
        phi_y = YW'(int'(phi_m) * PHI_CELLS);
        eta_x = 16'(eta);
        for (int i = 0; i < ETA_CELLS; i++)
        begin
            eta_hit[i] = (eta_x >= 16'(ETA_FIRST - ETA_HALF + ETA_STEP * i)) &&
                         (eta_x <= 16'(ETA_FIRST + ETA_HALF + ETA_STEP * i));
        end
        for (int j = 0; j < PHI_CELLS; j++)
        begin
            phi_hit[j] = ((phi_y >= YW'(j * PHI_CODES)) &&
                          (phi_y <= YW'((j + 1) * PHI_CODES))) ||
                         ((j == PHI_CELLS - 1) && (phi_y == '0));
        end
    end

    // lowest and highest hit on each axis
    always_comb
    begin
        span_next = '0;
        for (int i = ETA_CELLS - 1; i >= 0; i--)
        begin
            if (eta_hit[i])
            begin
                span_next.eta_lo = IDX_W'(i);
            end
        end
        for (int i = 0; i < ETA_CELLS; i++)
        begin
            if (eta_hit[i])
            begin
                span_next.eta_hi = IDX_W'(i);
            end
        end
        for (int j = PHI_CELLS - 1; j >= 0; j--)
        begin
            if (phi_hit[j])
            begin
                span_next.phi_lo = IDX_W'(j);
            end
        end
        for (int j = 0; j < PHI_CELLS; j++)
        begin
            if (phi_hit[j])
            begin
                span_next.phi_hi = IDX_W'(j);
            end
        end
        span_next.eta_any = |eta_hit;
        span_next.eta_two = span_next.eta_any && (span_next.eta_lo != span_next.eta_hi);
        span_next.phi_two = span_next.phi_lo != span_next.phi_hi;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            span_reg <= span_next;
        end
    end

    assign span = span_reg;

endmodule

[sv/gmed_rho.sv]
// gmed_rho: scales the sum of the two middle cell sums into rho
// depends on gmed_pkg; three register stages, result held until next start

module gmed_rho #(
    parameter int PHI_CELLS = gmed_pkg::PHI_CELLS_DEF,
    parameter int SUM_BITS  = gmed_pkg::SUM_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [SUM_BITS:0]          sum_ab,
    output logic                       done,
    output logic [gmed_pkg::RHO_W-1:0] rho
);

    import gmed_pkg::*;

    localparam int              KW      = 20;
    localparam longint unsigned RhoK    = longint'(RHO_MULT) * longint'(PHI_CELLS);
    localparam longint unsigned RhoDen  = longint'(RHO_DEN);
    // smallest sum whose scaled value overflows the rho field
    localparam longint unsigned SumLim  = ((64'd1 << RHO_W) * RhoDen + RhoK - 1) / RhoK;
    localparam logic [KW-1:0]   KConst  = KW'(RhoK);
    // floor(q / 5) = (q * Recip5) >> 34 for any 32-bit q
    localparam logic [31:0]     Recip5  = 32'hCCCCCCCD;

    logic                       v1_reg, v2_reg, v3_reg;
    logic                       over1_reg, over2_reg, over3_reg;
    logic [SCALED_W-1:0]        s_reg;
    logic [SCALED_W+KW-1:0]     prod_reg;
    logic [63:0]                quot_reg;

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // clip check, multiply by the area factor, divide by 5 * 2^16
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            over1_reg <= 64'(sum_ab) >= SumLim;
            s_reg     <= (64'(sum_ab) >= SumLim) ? '0 : SCALED_W'(sum_ab);
        end
        if (v1_reg)
        begin
            over2_reg <= over1_reg;
            prod_reg  <= s_reg * KConst;
        end
        if (v2_reg)
        begin
            over3_reg <= over2_reg;
            quot_reg  <= 64'(prod_reg[SCALED_W+KW-1:16]) * 64'(Recip5);
        end
    end

    assign done = v3_reg;
    assign rho  = over3_reg ? RHO_MAX : quot_reg[34+RHO_W-1:34];

endmodule

[sv/grid_median_energy_density.sv]
// grid_median_energy_density: top level, sequencer around the cell sum memory
// depends on gmed_pkg, gmed_ram, gmed_locate, gmed_rho
//
// Accumulates candidate pt into an ETA_CELLS x PHI_CELLS eta-phi grid held in
// one memory and, on the word marked last, returns rho = median cell sum
// scaled by the cell area, with a flag if any cell sum clipped. A candidate
// is taken in ST_IDLE, then gets a read (ST_RD) and a write (ST_WR) for each
// cell it touches (1 to 4 cells); a candidate outside every eta row gets
// only the read; a word with no candidate and no last is taken in ST_IDLE
// alone. At the end of an event the median is found by a bitwise rank
// search over the memory's single read port: SUM_BITS passes, each a scan of
// every cell, a drain and a decide step, then scaling in gmed_rho and a clear
// sweep over all ETA_CELLS*PHI_CELLS cells (80 for the default grid); the
// same sweep runs after reset. in_stall is high throughout. The result waits
// in an output register and does not hold up the next event's candidates.

module grid_median_energy_density #(
    parameter int ETA_CELLS = gmed_pkg::ETA_CELLS_DEF,
    parameter int PHI_CELLS = gmed_pkg::PHI_CELLS_DEF,
    parameter int SUM_BITS  = gmed_pkg::SUM_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [gmed_pkg::ETA_W-1:0] eta,
    input  logic [gmed_pkg::PHI_W-1:0]        phi,
    input  logic [gmed_pkg::PT_W-1:0]         pt,
    input  logic                              has_candidate,
    input  logic                              last,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [gmed_pkg::RHO_W-1:0]        rho,
    output logic                              saturated
);

    import gmed_pkg::*;

    localparam int NCells = ETA_CELLS * PHI_CELLS;
    localparam int AddrW  = $clog2(NCells);
    localparam int CntW   = $clog2(NCells + 1);
    localparam int RankLo = (NCells - 1) / 2;
    localparam int RankHi = NCells / 2;

    state_t              state_reg, state_next;
    logic [CntW-1:0]     k_reg, k_next;
    logic                e_sel_reg, e_sel_next;
    logic                p_sel_reg, p_sel_next;
    logic [PT_W-1:0]     pt_reg, pt_next;
    logic                last_reg, last_next;
    logic                clip_reg, clip_next;
    logic                dv_reg;
    logic [SUM_BITS-1:0] bsel_reg, bsel_next;
    logic [SUM_BITS-1:0] mask_reg, mask_next;
    logic [SUM_BITS-1:0] pfx_a_reg, pfx_a_next;
    logic [SUM_BITS-1:0] pfx_b_reg, pfx_b_next;
    logic [AddrW-1:0]    krem_a_reg, krem_a_next;
    logic [AddrW-1:0]    krem_b_reg, krem_b_next;
    logic [CntW-1:0]     cnt_a_reg, cnt_a_next;
    logic [CntW-1:0]     cnt_b_reg, cnt_b_next;
    logic                out_valid_reg, out_valid_next;
    logic [RHO_W-1:0]    rho_reg, rho_next;
    logic                sat_reg, sat_next;

    logic                accept;
    logic                start_sel;
    logic                rho_start;
    logic                rho_done;
    logic [RHO_W-1:0]    rho_val;
    logic [SUM_BITS:0]   sum_ab;
    logic [SUM_BITS:0]   sum_wide;
    logic                match_a, match_b;
    logic [IDX_W-1:0]    e_idx, p_idx;
    logic [AddrW-1:0]    cell_addr;
    cell_span_t          span;

    logic                ram_we;
    logic [AddrW-1:0]    ram_waddr;
    logic [SUM_BITS-1:0] ram_wdata;
    logic [AddrW-1:0]    ram_raddr;
    logic [SUM_BITS-1:0] ram_rdata;

    assign accept = in_valid && !in_stall;

    // cell sum memory
    gmed_ram #(
        .WIDTH (SUM_BITS),
        .DEPTH (NCells)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // candidate cell finder
    gmed_locate #(
        .ETA_CELLS (ETA_CELLS),
        .PHI_CELLS (PHI_CELLS)
    ) u_locate (
        .clk  (clk),
        .load (accept),
        .eta  (eta),
        .phi  (phi),
        .span (span)
    );

    // median scaling
    assign sum_ab = (SUM_BITS+1)'(pfx_a_reg) + (SUM_BITS+1)'(pfx_b_reg);

    gmed_rho #(
        .PHI_CELLS (PHI_CELLS),
        .SUM_BITS  (SUM_BITS)
    ) u_rho (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (rho_start),
        .sum_ab (sum_ab),
        .done   (rho_done),
        .rho    (rho_val)
    );

    // address of the cell being updated
    assign e_idx     = e_sel_reg ? span.eta_hi : span.eta_lo;
    assign p_idx     = p_sel_reg ? span.phi_hi : span.phi_lo;
    assign cell_addr = AddrW'(int'(e_idx) * PHI_CELLS + int'(p_idx));

    // saturating add for the read-modify-write
    assign sum_wide = (SUM_BITS+1)'(ram_rdata) + (SUM_BITS+1)'(pt_reg);

    // rank search: sums sharing the decided upper bits with a zero at this bit
    assign match_a = (((ram_rdata ^ pfx_a_reg) & mask_reg) == '0) &&
                     ((ram_rdata & bsel_reg) == '0);
    assign match_b = (((ram_rdata ^ pfx_b_reg) & mask_reg) == '0) &&
                     ((ram_rdata & bsel_reg) == '0);

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            k_reg         <= '0;
            clip_reg      <= 1'b0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            e_sel_reg     <= 1'b0;
            p_sel_reg     <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            clip_reg      <= clip_next;
            dv_reg        <= (state_reg == ST_SCAN);
            out_valid_reg <= out_valid_next;
            e_sel_reg     <= e_sel_next;
            p_sel_reg     <= p_sel_next;
            last_reg      <= last_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        pt_reg     <= pt_next;
        bsel_reg   <= bsel_next;
        mask_reg   <= mask_next;
        pfx_a_reg  <= pfx_a_next;
        pfx_b_reg  <= pfx_b_next;
        krem_a_reg <= krem_a_next;
        krem_b_reg <= krem_b_next;
        cnt_a_reg  <= cnt_a_next;
        cnt_b_reg  <= cnt_b_next;
        rho_reg    <= rho_next;
        sat_reg    <= sat_next;
    end

    // next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        e_sel_next     = e_sel_reg;
        p_sel_next     = p_sel_reg;
        pt_next        = pt_reg;
        last_next      = last_reg;
        clip_next      = clip_reg;
        bsel_next      = bsel_reg;
        mask_next      = mask_reg;
        pfx_a_next     = pfx_a_reg;
        pfx_b_next     = pfx_b_reg;
        krem_a_next    = krem_a_reg;
        krem_b_next    = krem_b_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        rho_next       = rho_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = (state_reg != ST_IDLE);
        ram_we         = 1'b0;
        ram_waddr      = cell_addr;
        ram_wdata      = '0;
        ram_raddr      = k_reg[AddrW-1:0];
        start_sel      = 1'b0;
        rho_start      = 1'b0;

        // count matches as scan data returns
        if (dv_reg)
        begin
            cnt_a_next = cnt_a_reg + CntW'(match_a);
            cnt_b_next = cnt_b_reg + CntW'(match_b);
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = k_reg[AddrW-1:0];
                if (k_reg == CntW'(NCells - 1))
                begin
                    k_next     = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pt_next    = pt;
                    last_next  = last;
                    e_sel_next = 1'b0;
                    p_sel_next = 1'b0;
                    if (has_candidate)
                    begin
                        state_next = ST_RD;
                    end
                    else if (last)
                    begin
                        start_sel = 1'b1;
                    end
                end
            end
            ST_RD:
            begin
                ram_raddr = cell_addr;
                if (span.eta_any)
                begin
                    state_next = ST_WR;
                end
                else if (last_reg)
                begin
                    start_sel = 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WR:
            begin
                // the next cell read starts after this write, so no overlap
                ram_we = 1'b1;
                if (sum_wide[SUM_BITS])
                begin
                    ram_wdata = '1;
                    clip_next = 1'b1;
                end
                else
                begin
                    ram_wdata = sum_wide[SUM_BITS-1:0];
                end
                if (!p_sel_reg && span.phi_two)
                begin
                    p_sel_next = 1'b1;
                    state_next = ST_RD;
                end
                else if (!e_sel_reg && span.eta_two)
                begin
                    e_sel_next = 1'b1;
                    p_sel_next = 1'b0;
                    state_next = ST_RD;
                end
                else if (last_reg)
                begin
                    start_sel = 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (k_reg == CntW'(NCells - 1))
                begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                // settle this bit of both ranked values
                if (CntW'(krem_a_reg) >= cnt_a_reg)
                begin
                    pfx_a_next  = pfx_a_reg | bsel_reg;
                    krem_a_next = krem_a_reg - AddrW'(cnt_a_reg);
                end
                if (CntW'(krem_b_reg) >= cnt_b_reg)
                begin
                    pfx_b_next  = pfx_b_reg | bsel_reg;
                    krem_b_next = krem_b_reg - AddrW'(cnt_b_reg);
                end
                cnt_a_next = '0;
                cnt_b_next = '0;
                if (bsel_reg[0])
                begin
                    state_next = ST_START;
                end
                else
                begin
                    bsel_next  = bsel_reg >> 1;
                    mask_next  = mask_reg | bsel_reg;
                    state_next = ST_SCAN;
                end
            end
            ST_START:
            begin
                rho_start  = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                if (rho_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    rho_next       = rho_val;
                    sat_next       = clip_reg;
                    clip_next      = 1'b0;
                    k_next         = '0;
                    state_next     = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // begin the median search from the top bit
        if (start_sel)
        begin
            bsel_next   = {1'b1, {(SUM_BITS-1){1'b0}}};
            mask_next   = '0;
            pfx_a_next  = '0;
            pfx_b_next  = '0;
            krem_a_next = AddrW'(RankLo);
            krem_b_next = AddrW'(RankHi);
            cnt_a_next  = '0;
            cnt_b_next  = '0;
            k_next      = '0;
            state_next  = ST_SCAN;
        end
    end

    assign out_valid = out_valid_reg;
    assign rho       = rho_reg;
    assign saturated = sat_reg;

endmodule

[sv/gmed_checker.sv]
// gmed_checker: port-level checks of the grid median energy density block
// no package use; bound to grid_median_energy_density below

module gmed_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        has_candidate,
    input logic        last,
    input logic        out_valid,
    input logic        out_stall,
    input logic [25:0] rho,
    input logic        saturated
);

    // a stalled result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(rho) && $stable(saturated))
        else $error("result word changed while stalled");

    // a word that does work keeps the input stalled the next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (has_candidate || last) |=> in_stall)
        else $error("input taken again while previous word still in work");

    // a new result appears only while the grid clear keeps the input stalled
    a_result_then_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_stall)
        else $error("result appeared without grid clear");

endmodule

bind grid_median_energy_density gmed_checker u_gmed_checker (.*);
